FILE: hdl/dons_pkg.sv
package dons_pkg;

  // field and state widths
  localparam int SUM_W      = 22;
  localparam int CNT_W      = 10;
  localparam int KNOWN_W    = 20;
  localparam int FULL_W     = 12;
  localparam int CODE_W     = 12;
  localparam int OHMS_W     = 40;
  localparam int IDX_W      = 6;
  localparam int STD_W      = 17;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // product widths
  localparam int NUM_W = KNOWN_W + SUM_W;
  localparam int FSN_W = FULL_W + CNT_W;

  localparam int STORED_ENTRIES = 54;

  localparam logic [OHMS_W-1:0] OHMS_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_OHMS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd2;

  // configuration reset values
  localparam logic [KNOWN_W-1:0] KNOWN_RESET  = 20'd10000;
  localparam logic [FULL_W-1:0]  FULL_RESET   = 12'd4095;
  localparam logic [CNT_W-1:0]   WINDOW_RESET = 10'd500;

  // one finished window handed from the front to the back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] n;
  } job_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] first;
    logic [DIGIT_W-1:0] second;
    logic [DIGIT_W-1:0] mult;
  } band_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_FSN,
    BK_MUL_NUM,
    BK_AVG_GO,
    BK_AVG_WAIT,
    BK_OHM_GO,
    BK_OHM_WAIT,
    BK_SEARCH,
    BK_OUT
  } back_state_t;

  // standard values in ohms
  localparam logic [STD_W-1:0] STD_OHMS [STORED_ENTRIES] = '{
    17'd510,   17'd560,   17'd620,   17'd680,   17'd750,   17'd820,   17'd910,
    17'd1000,  17'd1100,  17'd1200,  17'd1300,  17'd1500,  17'd1800,  17'd2000,
    17'd2200,  17'd2400,  17'd2700,  17'd3000,  17'd3300,  17'd3600,  17'd3900,
    17'd4300,  17'd4700,  17'd5100,  17'd5600,  17'd6200,  17'd6800,  17'd7500,
    17'd8200,  17'd9100,  17'd10000, 17'd11000, 17'd12000, 17'd13000, 17'd15000,
    17'd18000, 17'd20000, 17'd22000, 17'd24000, 17'd27000, 17'd30000, 17'd33000,
    17'd36000, 17'd39000, 17'd43000, 17'd47000, 17'd51000, 17'd56000, 17'd62000,
    17'd68000, 17'd75000, 17'd82000, 17'd91000, 17'd100000
  };

  // color bands packed as first digit, second digit, multiplier
  localparam logic [3*DIGIT_W-1:0] BAND_CODE [STORED_ENTRIES] = '{
    12'h511, 12'h561, 12'h621, 12'h681, 12'h751, 12'h821, 12'h911,
    12'h102, 12'h112, 12'h122, 12'h132, 12'h152, 12'h182, 12'h202,
    12'h222, 12'h242, 12'h272, 12'h302, 12'h332, 12'h362, 12'h392,
    12'h432, 12'h472, 12'h512, 12'h562, 12'h622, 12'h682, 12'h752,
    12'h822, 12'h912, 12'h103, 12'h113, 12'h123, 12'h133, 12'h153,
    12'h183, 12'h203, 12'h223, 12'h243, 12'h273, 12'h303, 12'h333,
    12'h363, 12'h393, 12'h433, 12'h473, 12'h513, 12'h563, 12'h623,
    12'h683, 12'h753, 12'h823, 12'h913, 12'h104
  };

  function automatic logic [STD_W-1:0] std_ohms(input logic [IDX_W-1:0] idx);
    logic [STD_W-1:0] v;
    v = '0;
    if (idx < IDX_W'(STORED_ENTRIES)) v = STD_OHMS[idx];
    return v;
  endfunction

  function automatic band_t band_of(input logic [IDX_W-1:0] idx);
    band_t b;
    b = '0;
    if (idx < IDX_W'(STORED_ENTRIES)) b = band_t'(BAND_CODE[idx]);
    return b;
  endfunction

endpackage

FILE: hdl/dons_divider.sv
module dons_divider #(
  parameter int DW = 51,
  parameter int VW = 22
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder
);

  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] dsor;
  logic [VW:0]   rem_sh;
  logic [VW:0]   rem_diff;
  logic          fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    rem_sh   = {remainder, quotient[DW-1]};
    rem_diff = rem_sh - {1'b0, dsor};
    fits     = (rem_sh >= {1'b0, dsor});
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsor      <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DW-2:0], fits};
      remainder <= fits ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

FILE: hdl/dons_front.sv
module dons_front import dons_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [CODE_W-1:0] sample_code,
  input  logic [CNT_W-1:0]  window_length,
  input  logic              queue_full,
  output logic              job_push,
  output job_t              job
);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] n_eff;
  logic             window_end;
  logic             accept;

  // accumulate and detect window end
  always_comb begin
    n_eff      = (window_length == '0) ? CNT_W'(1) : window_length;
    sum_next   = sum + SUM_W'(sample_code);
    count_next = count + 1'b1;
    window_end = (count_next >= n_eff);
    accept     = push && !queue_full;
    full       = queue_full;
    job_push   = accept && window_end;
    job.sum    = sum_next;
    job.n      = n_eff;
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (window_end) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count_next;
      end
    end
  end

endmodule

FILE: hdl/dons_queue.sv
module dons_queue import dons_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic valid
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_comb begin
    full  = (fill == 2'd2);
    valid = (fill != 2'd0);
    dout  = slot[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

endmodule

FILE: hdl/dons_back.sv
module dons_back import dons_pkg::*; #(
  parameter int TABLE_ENTRIES = 54,
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  job_t               job,
  input  logic               job_valid,
  output logic               job_pop,
  input  logic [KNOWN_W-1:0] known_resistor_ohms,
  input  logic [FULL_W-1:0]  full_scale_code,
  output logic               empty,
  input  logic               pop,
  output logic [CODE_W-1:0]  average_code,
  output logic [OHMS_W-1:0]  measured_ohms_q8,
  output logic               saturated,
  output logic [IDX_W-1:0]   nearest_index,
  output logic [STD_W-1:0]   nearest_ohms,
  output logic [DIGIT_W-1:0] band_first,
  output logic [DIGIT_W-1:0] band_second,
  output logic [DIGIT_W-1:0] band_multiplier
);

  localparam int N_EFF = (TABLE_ENTRIES > STORED_ENTRIES) ? STORED_ENTRIES :
                         ((TABLE_ENTRIES < 1) ? 1 : TABLE_ENTRIES);
  localparam int DW     = NUM_W + FRACTION_BITS + 1;
  localparam int BW     = DW - FRACTION_BITS;
  localparam int PAIR_W = STD_W + 1;
  localparam logic [DW-1:0]    FRAC_MASK = DW'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(N_EFF - 1);

  back_state_t state;
  back_state_t state_next;

  // job registers
  logic [SUM_W-1:0]  job_sum;
  logic [CNT_W-1:0]  job_n;
  logic [FSN_W-1:0]  fsn;
  logic [NUM_W-1:0]  num;
  logic [FSN_W-1:0]  den;
  logic              den_bad;
  logic [CODE_W-1:0] avg;
  logic [OHMS_W-1:0] ohms;
  logic              sat;
  logic [BW-1:0]     quot_b;
  logic              inexact;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  scan;
  logic              out_valid;

  // divider hookup
  logic              div_start;
  logic [DW-1:0]     div_dividend;
  logic [FSN_W-1:0]  div_divisor;
  logic              div_done;
  logic [DW-1:0]     div_quo;
  logic [FSN_W-1:0]  div_rem;
  logic [SUM_W:0]    avg_dividend;

  // rounding of the quotient and search compares
  logic [DW:0]       a_plus;
  logic [DW-1:0]     q_full;
  logic              clip;
  logic [STD_W-1:0]  s_cur;
  logic [STD_W-1:0]  s_prev;
  logic [PAIR_W-1:0] twice;
  logic [PAIR_W-1:0] pair;
  logic              below;
  logic              scan_more;
  logic [IDX_W-1:0]  idx_found;
  logic              load;
  band_t             band;

  dons_divider #(
    .DW(DW),
    .VW(FSN_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // divider operands: rounded average first, then the resistance
  always_comb begin
    avg_dividend = (SUM_W + 1)'(job_sum) + (SUM_W + 1)'(job_n >> 1);
    if (state == BK_OHM_GO) begin
      div_dividend = DW'(num) << (FRACTION_BITS + 1);
      div_divisor  = den;
    end else begin
      div_dividend = DW'(avg_dividend);
      div_divisor  = FSN_W'(job_n);
    end
  end

  // q = floor((A + 1) / 2) with A = floor(num * 2^(F+1) / den)
  always_comb begin
    a_plus = (DW + 1)'(div_quo) + 1'b1;
    q_full = a_plus[DW:1];
    clip   = |q_full[DW-1:OHMS_W];
  end

  // nearest entry scan on B = floor(2 * num / den)
  always_comb begin
    s_cur     = std_ohms(scan);
    s_prev    = std_ohms(scan - 1'b1);
    twice     = {s_cur, 1'b0};
    pair      = PAIR_W'(s_cur) + PAIR_W'(s_prev);
    below     = (BW'(twice) < quot_b) || ((BW'(twice) == quot_b) && inexact);
    scan_more = (scan < IDX_W'(N_EFF)) && below;
    if (scan >= IDX_W'(N_EFF)) begin
      idx_found = LAST_IDX;
    end else if (scan == '0) begin
      idx_found = '0;
    end else if (BW'(pair) <= quot_b) begin
      idx_found = scan;
    end else begin
      idx_found = scan - 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:     if (job_valid) state_next = BK_MUL_FSN;
      BK_MUL_FSN:  state_next = BK_MUL_NUM;
      BK_MUL_NUM:  state_next = BK_AVG_GO;
      BK_AVG_GO:   state_next = BK_AVG_WAIT;
      BK_AVG_WAIT: if (div_done) state_next = den_bad ? BK_OUT : BK_OHM_GO;
      BK_OHM_GO:   state_next = BK_OHM_WAIT;
      BK_OHM_WAIT: if (div_done) state_next = BK_SEARCH;
      BK_SEARCH:   if (!scan_more) state_next = BK_OUT;
      BK_OUT:      if (load) state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    job_pop   = (state == BK_IDLE) && job_valid;
    div_start = (state == BK_AVG_GO) || (state == BK_OHM_GO);
    load      = (state == BK_OUT) && (!out_valid || pop);
    empty     = !out_valid;
    band      = band_of(idx);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= load || (out_valid && !pop);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (job_valid) begin
          job_sum <= job.sum;
          job_n   <= job.n;
        end
      end
      BK_MUL_FSN: begin
        fsn <= FSN_W'(full_scale_code) * FSN_W'(job_n);
      end
      BK_MUL_NUM: begin
        num     <= NUM_W'(known_resistor_ohms) * NUM_W'(job_sum);
        den_bad <= (job_sum >= fsn);
        den     <= fsn - job_sum;
      end
      BK_AVG_WAIT: begin
        if (div_done) begin
          avg  <= div_quo[CODE_W-1:0];
          ohms <= OHMS_MAX;
          sat  <= den_bad;
          idx  <= LAST_IDX;
        end
      end
      BK_OHM_WAIT: begin
        if (div_done) begin
          ohms    <= clip ? OHMS_MAX : q_full[OHMS_W-1:0];
          sat     <= clip;
          quot_b  <= div_quo[DW-1:FRACTION_BITS];
          inexact <= (|(div_quo & FRAC_MASK)) || (|div_rem);
          scan    <= '0;
        end
      end
      BK_SEARCH: begin
        if (scan_more) begin
          scan <= scan + 1'b1;
        end else begin
          idx <= idx_found;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      average_code     <= avg;
      measured_ohms_q8 <= ohms;
      saturated        <= sat;
      nearest_index    <= idx;
      nearest_ohms     <= std_ohms(idx);
      band_first       <= band.first;
      band_second      <= band.second;
      band_multiplier  <= band.mult;
    end
  end

  // divider finishes only while the sequencer waits for it
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == BK_AVG_WAIT || state == BK_OHM_WAIT))
    else $error("divider done outside a wait state");

  // the table scan runs only for a positive denominator
  a_search_den_ok: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEARCH) |-> !den_bad)
    else $error("table scan with non-positive denominator");

  // non-positive denominator gives a saturated result on the last entry
  a_bad_den_result: assert property (@(posedge clk) disable iff (rst)
    (state == BK_OUT && den_bad) |-> (sat && idx == LAST_IDX))
    else $error("bad denominator result not saturated");

  // the scan index never runs more than one past the last table entry
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == BK_SEARCH) |-> (scan <= IDX_W'(N_EFF)))
    else $error("table scan out of range");

endmodule

FILE: hdl/divider_ohmmeter_nearest_standard_unit.sv
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+-------------------------------------
// samples   | in        | push / full               | sample_code
// results   | out       | empty / pop               | average_code .. band_multiplier
// config    | in        | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// one sample is taken every cycle while full is low; the front keeps the window sum
// the back handles one window at a time, in order:
// two passes of the bit-serial divider, then a scan of the standard table
// a two-entry window queue and the result register let front and back stall apart;
// full rises only while two finished windows wait for the back
// synchronous reset clears the window and loads the default register values
module divider_ohmmeter_nearest_standard_unit import dons_pkg::*; #(
  parameter int TABLE_ENTRIES = 54,
  parameter int FRACTION_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic [CODE_W-1:0]     sample_code,
  output logic                  empty,
  input  logic                  pop,
  output logic [CODE_W-1:0]     average_code,
  output logic [OHMS_W-1:0]     measured_ohms_q8,
  output logic                  saturated,
  output logic [IDX_W-1:0]      nearest_index,
  output logic [STD_W-1:0]      nearest_ohms,
  output logic [DIGIT_W-1:0]    band_first,
  output logic [DIGIT_W-1:0]    band_second,
  output logic [DIGIT_W-1:0]    band_multiplier,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [KNOWN_W-1:0] known_resistor_ohms;
  logic [FULL_W-1:0]  full_scale_code;
  logic [CNT_W-1:0]   window_length;

  logic queue_full;
  logic job_push;
  logic job_pop;
  logic job_valid;
  job_t front_job;
  job_t back_job;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      known_resistor_ohms <= KNOWN_RESET;
      full_scale_code     <= FULL_RESET;
      window_length       <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KNOWN_OHMS:    known_resistor_ohms <= cfg_data[KNOWN_W-1:0];
        REG_FULL_SCALE:    full_scale_code     <= cfg_data[FULL_W-1:0];
        REG_WINDOW_LENGTH: window_length       <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dons_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .sample_code   (sample_code),
    .window_length (window_length),
    .queue_full    (queue_full),
    .job_push      (job_push),
    .job           (front_job)
  );

  dons_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (front_job),
    .full  (queue_full),
    .pop   (job_pop),
    .dout  (back_job),
    .valid (job_valid)
  );

  dons_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .job                 (back_job),
    .job_valid           (job_valid),
    .job_pop             (job_pop),
    .known_resistor_ohms (known_resistor_ohms),
    .full_scale_code     (full_scale_code),
    .empty               (empty),
    .pop                 (pop),
    .average_code        (average_code),
    .measured_ohms_q8    (measured_ohms_q8),
    .saturated           (saturated),
    .nearest_index       (nearest_index),
    .nearest_ohms        (nearest_ohms),
    .band_first          (band_first),
    .band_second         (band_second),
    .band_multiplier     (band_multiplier)
  );

endmodule

FILE: tb/divider_ohmmeter_nearest_standard_unit_tb.sv
`timescale 1ns / 100ps

module divider_ohmmeter_nearest_standard_unit_tb;
  import dons_pkg::*;

  localparam int SETTLE_CYCLES = 250;
  localparam int HOLD_CYCLES = 3000;
  localparam int SAMPLE_GOAL = 1850;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam int ENTRIES = 54;
  localparam int Q_BITS = 8;
  localparam int CODE_MAX = 4095;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam longint unsigned Q_MAX = (64'd1 << OHMS_W) - 64'd1;

  // standard resistor series, ohms
  localparam longint unsigned E24_OHMS [ENTRIES] = '{
    510, 560, 620, 680, 750, 820, 910, 1000, 1100, 1200, 1300, 1500,
    1800, 2000, 2200, 2400, 2700, 3000, 3300, 3600, 3900, 4300, 4700, 5100,
    5600, 6200, 6800, 7500, 8200, 9100, 10000, 11000, 12000, 13000, 15000,
    18000, 20000, 22000, 24000, 27000, 30000, 33000, 36000, 39000, 43000,
    47000, 51000, 56000, 62000, 68000, 75000, 82000, 91000, 100000
  };

  typedef struct {
    logic [CODE_W-1:0]  average;
    logic [OHMS_W-1:0]  ohms_q8;
    logic               sat;
    logic [IDX_W-1:0]   idx;
    logic [STD_W-1:0]   standard;
    logic [DIGIT_W-1:0] first;
    logic [DIGIT_W-1:0] second;
    logic [DIGIT_W-1:0] mult;
  } reading_t;

  // window accumulator and divider math, plus the readings still owed
  class ohm_scoreboard;
    logic [KNOWN_W-1:0] known_ohms;
    logic [FULL_W-1:0]  full_code;
    logic [CNT_W-1:0]   window_len;
    logic [SUM_W-1:0]   acc_sum;
    logic [CNT_W-1:0]   acc_count;
    reading_t           pending_q[$];
    int                 errors;

    function new();
      known_ohms = 20'd10000;
      full_code  = 12'd4095;
      window_len = 10'd500;
      acc_sum    = '0;
      acc_count  = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KNOWN_OHMS: begin
          known_ohms = data[KNOWN_W-1:0];
        end
        REG_FULL_SCALE: begin
          full_code = data[FULL_W-1:0];
        end
        REG_WINDOW_LENGTH: begin
          window_len = data[CNT_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // closest entry to num/den, ties go up
    function int unsigned nearest_entry(longint unsigned num, longint unsigned den);
      int unsigned i;
      i = 0;
      while (i < ENTRIES && E24_OHMS[i] * den < num) i++;
      if (i >= ENTRIES) return ENTRIES - 1;
      if (i == 0) return 0;
      if ((E24_OHMS[i] + E24_OHMS[i-1]) * den <= 2 * num) return i;
      return i - 1;
    endfunction

    function void note_sample(logic [CODE_W-1:0] code);
      longint unsigned n, total, fsn, den, num, q, v;
      int unsigned idx, mult;
      reading_t r;
      acc_sum = acc_sum + SUM_W'(code);
      acc_count = acc_count + CNT_W'(1);
      n = (window_len == '0) ? 64'd1 : 64'(window_len);
      if (64'(acc_count) < n) return;
      total = 64'(acc_sum);
      acc_sum = '0;
      acc_count = '0;
      fsn = 64'(full_code) * n;
      q = Q_MAX;
      r.sat = 1'b0;
      // denominator zero or negative saturates to the top entry
      if (total >= fsn) begin
        r.sat = 1'b1;
        idx = ENTRIES - 1;
      end else begin
        den = fsn - total;
        num = 64'(known_ohms) * total;
        q = ((num << Q_BITS) * 2 + den) / (2 * den);
        if (q > Q_MAX) begin
          q = Q_MAX;
          r.sat = 1'b1;
        end
        idx = nearest_entry(num, den);
      end
      // color bands from the decimal digits
      v = E24_OHMS[idx];
      mult = 0;
      while (v >= 100) begin
        v = v / 10;
        mult++;
      end
      r.average  = CODE_W'((total + n / 2) / n);
      r.ohms_q8  = OHMS_W'(q);
      r.idx      = IDX_W'(idx);
      r.standard = STD_W'(E24_OHMS[idx]);
      r.first    = DIGIT_W'(v / 10);
      r.second   = DIGIT_W'(v % 10);
      r.mult     = DIGIT_W'(mult);
      pending_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task compare(string field, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (pending_q.size() == 0) begin
        report("reading with no window pending");
        return;
      end
      want = pending_q.pop_front();
      compare("average_code", 64'(got.average), 64'(want.average));
      compare("measured_ohms_q8", 64'(got.ohms_q8), 64'(want.ohms_q8));
      compare("saturated", 64'(got.sat), 64'(want.sat));
      compare("nearest_index", 64'(got.idx), 64'(want.idx));
      compare("nearest_ohms", 64'(got.standard), 64'(want.standard));
      compare("band_first", 64'(got.first), 64'(want.first));
      compare("band_second", 64'(got.second), 64'(want.second));
      compare("band_multiplier", 64'(got.mult), 64'(want.mult));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  logic [CODE_W-1:0]     sample_code = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [CODE_W-1:0]     average_code;
  logic [OHMS_W-1:0]     measured_ohms_q8;
  logic                  saturated;
  logic [IDX_W-1:0]      nearest_index;
  logic [STD_W-1:0]      nearest_ohms;
  logic [DIGIT_W-1:0]    band_first;
  logic [DIGIT_W-1:0]    band_second;
  logic [DIGIT_W-1:0]    band_multiplier;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit              steady = 1'b0;
  bit              hold_req = 1'b0;
  int unsigned     samples_sent = 0;
  longint unsigned cycle_count = 0;
  ohm_scoreboard   book;

  divider_ohmmeter_nearest_standard_unit dut (.*);

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random pop, one long hold-off on request
  initial begin : result_side
    reading_t got;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.average  = average_code;
        got.ohms_q8  = measured_ohms_q8;
        got.sat      = saturated;
        got.idx      = nearest_index;
        got.standard = nearest_ohms;
        got.first    = band_first;
        got.second   = band_second;
        got.mult     = band_multiplier;
        book.check_reading(got);
      end
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      pop <= steady || ($urandom_range(99) >= 7);
    end
  end

  // one sample request, with random gaps ahead of it unless steady is set
  task automatic send_sample(input logic [CODE_W-1:0] code);
    if (!steady) begin
      while ($urandom_range(99) < 7) begin
        push <= 1'b0;
        @(negedge clk);
      end
    end
    push <= 1'b1;
    sample_code <= code;
    do @(posedge clk); while (full);
    book.note_sample(code);
    samples_sent++;
    @(negedge clk);
  endtask

  // samples around a target code with a little noise and rare wild values
  task automatic send_window(input int unsigned len, input int unsigned target);
    int c;
    int unsigned spread;
    spread = $urandom_range(3);
    repeat (len) begin
      if ($urandom_range(15) == 0) c = int'($urandom_range(CODE_MAX));
      else c = int'(target) + int'($urandom_range(2 * spread)) - int'(spread);
      if (c < 0) c = 0;
      if (c > CODE_MAX) c = CODE_MAX;
      send_sample(CODE_W'(c));
    end
  endtask

  // wait until every reading is back and the back end has gone quiet
  task automatic settle();
    push <= 1'b0;
    @(negedge clk);
    while (book.pending_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    book.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper data bits carry junk
  task automatic set_config(input logic [KNOWN_W-1:0] known, input logic [FULL_W-1:0] fs,
                            input logic [CNT_W-1:0] win);
    settle();
    write_reg(REG_KNOWN_OHMS, known);
    write_reg(REG_FULL_SCALE, {8'($urandom), fs});
    write_reg(REG_WINDOW_LENGTH, {10'($urandom), win});
  endtask

  // average code that lands near a standard value, or an edge, or anything
  function automatic int unsigned aim_code(longint unsigned known, longint unsigned fs);
    longint unsigned r;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      r = E24_OHMS[$urandom_range(ENTRIES - 1)];
      return int'((fs * r + (known + r) / 2) / (known + r));
    end
    if (pick < 80) return $urandom_range(CODE_MAX);
    if (pick < 90) return (fs > 0 && $urandom_range(1) == 1) ? int'(fs - 1) : int'(fs);
    return $urandom_range(1) == 1 ? CODE_MAX : 0;
  endfunction

  initial begin : stimulus
    int unsigned phase, pick, n_eff, wins;
    logic [KNOWN_W-1:0] known;
    logic [FULL_W-1:0] fs;
    logic [CNT_W-1:0] win;
    book = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one window at the reset register values
    send_window(500, aim_code(10000, 4095));

    // halfway between the two lowest entries goes up; zero, full scale and above
    set_config(20'd535, 12'd2, 10'd1);
    send_sample(12'd1);
    send_sample(12'd0);
    send_sample(12'd2);
    send_sample(12'd4095);
    // tie and near-tie between the two highest entries
    set_config(20'd95500, 12'd2, 10'd1);
    send_sample(12'd1);
    set_config(20'd95499, 12'd2, 10'd1);
    send_sample(12'd1);
    // denominator of one with the largest resistor: quotient clips
    set_config(20'hFFFFF, 12'd4095, 10'd2);
    send_sample(12'd4095);
    send_sample(12'd4094);
    // zero resistor, zero window length acts as one sample
    set_config(20'd0, 12'd4095, 10'd0);
    send_sample(12'd2048);
    send_sample(12'd4095);
    // zero full scale always saturates
    set_config(20'd10000, 12'd0, 10'd1);
    send_sample(12'd0);
    // long window cut short partway through
    set_config(20'd10000, 12'd4095, 10'd1023);
    send_window(5, 2048);
    set_config(20'd10000, 12'd4095, 10'd3);
    send_sample(12'd1000);
    // write to the unmapped register index
    settle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));

    // random phases
    phase = 0;
    while (samples_sent < SAMPLE_GOAL) begin
      phase++;
      steady = (phase >= 6 && phase < 10);
      pick = $urandom_range(99);
      if (pick < 15) known = 20'd10000;
      else if (pick < 30) known = 20'hFFFFF;
      else if (pick < 42) known = KNOWN_W'($urandom_range(1, 100));
      else if (pick < 44) known = '0;
      else known = KNOWN_W'($urandom_range(1, 20'hFFFFF));
      pick = $urandom_range(99);
      if (pick < 40) fs = 12'd4095;
      else if (pick < 50) fs = FULL_W'($urandom_range(1, 15));
      else if (pick < 53) fs = '0;
      else fs = FULL_W'($urandom_range(1, 4095));
      pick = $urandom_range(99);
      if (phase == 3) win = 10'd1;
      else if (pick < 45) win = CNT_W'($urandom_range(1, 4));
      else if (pick < 80) win = CNT_W'($urandom_range(5, 16));
      else if (pick < 92) win = CNT_W'($urandom_range(17, 64));
      else if (pick < 96) win = '0;
      else win = CNT_W'($urandom_range(65, 200));
      set_config(known, fs, win);
      n_eff = (win == '0) ? 1 : int'(win);
      // result side stalls while samples keep coming, so the input backs up
      if (phase == 3) hold_req = 1'b1;
      wins = (phase == 3) ? 12 : $urandom_range(2, 8);
      for (int w = 0; w < int'(wins) && samples_sent < SAMPLE_GOAL; w++)
        send_window(n_eff, aim_code(64'(known), 64'(fs)));
      // sometimes leave a partial window open across the next register change
      if ($urandom_range(4) == 0 && samples_sent < SAMPLE_GOAL)
        send_window($urandom_range(1, n_eff), aim_code(64'(known), 64'(fs)));
    end
    steady = 1'b0;

    settle();
    if (book.errors == 0 && book.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/dons_pkg.sv
hdl/dons_divider.sv
hdl/dons_front.sv
hdl/dons_queue.sv
hdl/dons_back.sv
hdl/divider_ohmmeter_nearest_standard_unit.sv
tb/divider_ohmmeter_nearest_standard_unit_tb.sv
